>>> hw/rtl/pwmsr_pkg.sv
// pwmsr_pkg: shared sizes, action codes and controller/datapath structs
// for the PWM shift register tube driver. No dependencies.
package pwmsr_pkg;

  // Display geometry
  localparam int DIGIT_TUBES     = 6;
  localparam int DIGITS_PER_TUBE = 10;
  localparam int COLON_GROUPS    = 2;
  localparam int DOTS_PER_COLON  = 2;
  localparam int BRIGHT_STEPS    = 64;

  localparam int NUM_DIGITS = DIGIT_TUBES * DIGITS_PER_TUBE;
  localparam int NUM_DOTS   = COLON_GROUPS * DOTS_PER_COLON;
  localparam int NUM_ELEMS  = NUM_DIGITS + NUM_DOTS;

  localparam int ELEM_IDX_W = (NUM_ELEMS > 1) ? $clog2(NUM_ELEMS) : 1;
  localparam int DIG_IDX_W  = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
  localparam int DOT_IDX_W  = (NUM_DOTS > 1) ? $clog2(NUM_DOTS) : 1;

  // Fixed field widths
  localparam int ACTION_W = 3;
  localparam int ELEM_W   = 6;
  localparam int BRIGHT_W = 8;
  localparam int TIME_W   = 32;
  localparam int BITPOS_W = 6;
  localparam int DOTS_W   = 4;

  localparam logic [ELEM_IDX_W-1:0] DIG_LIMIT = ELEM_IDX_W'(NUM_DIGITS);

  // Action codes
  localparam logic [ACTION_W-1:0] ACT_SET_BRIGHT = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_SET_POS    = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_ALL_ZERO   = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_ALL_MAX    = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_READ       = 3'd4;
  localparam logic [ACTION_W-1:0] ACT_TICK       = 3'd5;

  // Controller -> datapath
  typedef struct packed {
    logic wr_bright;
    logic wr_pos;
    logic fill_zero;
    logic fill_max;
    logic rd_issue;
    logic rd_load;
    logic scan_start;
    logic scan_step;
    logic emit_load;
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic out_valid;
    logic out_free;
    logic scan_last;
    logic emit_last;
  } st_t;

endpackage

>>> hw/rtl/pwmsr_datapath.sv
// pwmsr_datapath: brightness and position memories, scan pipeline,
// driven-position vector and output register. Uses pwmsr_pkg.
module pwmsr_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  pwmsr_pkg::cmd_t                cmd_i,
  output pwmsr_pkg::st_t                 st_o,
  input  logic [pwmsr_pkg::ELEM_W-1:0]   elem_sel_i,
  input  logic [pwmsr_pkg::BRIGHT_W-1:0] value_i,
  input  logic [pwmsr_pkg::TIME_W-1:0]   time_ms_i,
  input  logic                           out_stall_i,
  output logic                           out_valid_o,
  output logic                           serial_bit_o,
  output logic [pwmsr_pkg::BITPOS_W-1:0] bit_position_o,
  output logic [pwmsr_pkg::DOTS_W-1:0]   colon_dots_o,
  output logic [pwmsr_pkg::BRIGHT_W-1:0] read_value_o,
  output logic                           last_o
);
  import pwmsr_pkg::*;

  // Memories
  logic [BRIGHT_W-1:0]  bright_mem [NUM_ELEMS];
  logic [DIG_IDX_W-1:0] pos_mem    [NUM_DIGITS];

  // valid bits stand in for the table reset and the fill actions
  logic [NUM_ELEMS-1:0] bright_vld_q;
  logic [BRIGHT_W-1:0]  fill_q;

  logic [BRIGHT_W-1:0]   bright_rd_q;
  logic                  vld_rd_q;
  logic [DIG_IDX_W-1:0]  pos_rd_q;
  logic                  rd_ok_q;

  logic [ELEM_IDX_W-1:0] scan_idx_q;
  logic                  s1_vld_q;
  logic [ELEM_IDX_W-1:0] s1_idx_q;
  logic [BRIGHT_W-1:0]   phase_q;
  logic [NUM_DIGITS-1:0] driven_q;
  logic [NUM_DOTS-1:0]   dots_q;
  logic [DIG_IDX_W-1:0]  emit_pos_q;

  logic                  out_valid_q;
  logic                  out_bit_q;
  logic [BITPOS_W-1:0]   out_pos_q;
  logic [DOTS_W-1:0]     out_dots_q;
  logic [BRIGHT_W-1:0]   out_rd_q;
  logic                  out_last_q;

  logic                  elem_ok;
  logic                  elem_dig;
  logic                  pos_ok;
  logic [ELEM_IDX_W-1:0] raddr;
  logic                  rd_en;
  logic [BRIGHT_W-1:0]   bright_val;
  logic                  lit;
  logic                  s1_is_digit;
  logic                  pos_in_range;
  logic [DOT_IDX_W-1:0]  dot_idx;
  logic                  emit_last;

  assign elem_ok   = {1'b0, elem_sel_i} < (ELEM_W + 1)'(NUM_ELEMS);
  assign elem_dig  = {1'b0, elem_sel_i} < (ELEM_W + 1)'(NUM_DIGITS);
  assign pos_ok    = {1'b0, value_i} < (BRIGHT_W + 1)'(NUM_DIGITS);
  assign raddr     = cmd_i.rd_issue ? ELEM_IDX_W'(elem_sel_i) : scan_idx_q;
  assign rd_en     = cmd_i.rd_issue | cmd_i.scan_step;
  assign bright_val = vld_rd_q ? bright_rd_q : fill_q;
  assign lit        = bright_val > phase_q;
  assign s1_is_digit  = s1_idx_q < DIG_LIMIT;
  assign pos_in_range = {1'b0, pos_rd_q} < (DIG_IDX_W + 1)'(NUM_DIGITS);
  assign dot_idx      = DOT_IDX_W'(s1_idx_q - DIG_LIMIT);
  assign emit_last    = emit_pos_q == '0;

  // Memory ports
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_bright && elem_ok) begin
      bright_mem[ELEM_IDX_W'(elem_sel_i)] <= value_i;
    end
    if (rd_en) begin
      bright_rd_q <= bright_mem[raddr];
      vld_rd_q    <= bright_vld_q[raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_pos && elem_dig && pos_ok) begin
      pos_mem[DIG_IDX_W'(elem_sel_i)] <= DIG_IDX_W'(value_i);
    end
    if (cmd_i.scan_step && (scan_idx_q < DIG_LIMIT)) begin
      pos_rd_q <= pos_mem[DIG_IDX_W'(scan_idx_q)];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bright_vld_q <= '0;
      fill_q       <= '0;
    end else if (cmd_i.fill_zero) begin
      bright_vld_q <= '0;
      fill_q       <= '0;
    end else if (cmd_i.fill_max) begin
      bright_vld_q <= '0;
      fill_q       <= BRIGHT_W'(BRIGHT_STEPS);
    end else if (cmd_i.wr_bright && elem_ok) begin
      bright_vld_q[ELEM_IDX_W'(elem_sel_i)] <= 1'b1;
    end
  end

  // Tick payload state
  always_ff @(posedge clk_i) begin
    s1_idx_q <= scan_idx_q;
    if (cmd_i.rd_issue) begin
      rd_ok_q <= elem_ok;
    end
    if (cmd_i.scan_start) begin
      phase_q  <= BRIGHT_W'(time_ms_i % BRIGHT_STEPS);
      driven_q <= '0;
      dots_q   <= '0;
    end else if (s1_vld_q) begin
      if (s1_is_digit) begin
        if (lit && pos_in_range) begin
          driven_q[pos_rd_q] <= 1'b1;
        end
      end else begin
        dots_q[dot_idx] <= lit;
      end
    end
  end

  // Scan and emit counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_idx_q <= '0;
      s1_vld_q   <= 1'b0;
      emit_pos_q <= '0;
    end else begin
      s1_vld_q <= cmd_i.scan_step;
      if (cmd_i.scan_start) begin
        scan_idx_q <= '0;
        emit_pos_q <= DIG_IDX_W'(NUM_DIGITS - 1);
      end else begin
        if (cmd_i.scan_step) begin
          scan_idx_q <= scan_idx_q + 1'b1;
        end
        if (cmd_i.emit_load) begin
          emit_pos_q <= emit_pos_q - 1'b1;
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.rd_load || cmd_i.emit_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_load) begin
      out_bit_q  <= 1'b1;
      out_pos_q  <= '0;
      out_dots_q <= '0;
      out_rd_q   <= rd_ok_q ? bright_val : '0;
      out_last_q <= 1'b0;
    end else if (cmd_i.emit_load) begin
      out_bit_q  <= ~driven_q[emit_pos_q];
      out_pos_q  <= BITPOS_W'(emit_pos_q);
      out_dots_q <= emit_last ? DOTS_W'(dots_q) : '0;
      out_rd_q   <= '0;
      out_last_q <= emit_last;
    end
  end

  assign st_o.out_valid = out_valid_q;
  assign st_o.out_free  = ~out_valid_q | ~out_stall_i;
  assign st_o.scan_last = scan_idx_q == ELEM_IDX_W'(NUM_ELEMS - 1);
  assign st_o.emit_last = emit_last;

  assign out_valid_o    = out_valid_q;
  assign serial_bit_o   = out_bit_q;
  assign bit_position_o = out_pos_q;
  assign colon_dots_o   = out_dots_q;
  assign read_value_o   = out_rd_q;
  assign last_o         = out_last_q;

  // Loads never overwrite an item still held by the sink
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.rd_load || cmd_i.emit_load) |-> (!out_valid_q || !out_stall_i))
    else $error("output register overwritten while stalled");

  a_last_pos0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_last_q) |-> (out_pos_q == '0))
    else $error("last item not at position zero");

  a_scan_no_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_vld_q |-> !cmd_i.emit_load)
    else $error("emit started before scan finished");

endmodule

>>> hw/rtl/pwmsr_ctrl.sv
// pwmsr_ctrl: sequencer for actions, read-back and refresh ticks.
// Uses pwmsr_pkg; drives pwmsr_datapath through cmd_t / st_t.
module pwmsr_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic [pwmsr_pkg::ACTION_W-1:0] action_i,
  output logic                           in_stall_o,
  input  pwmsr_pkg::st_t                 st_i,
  output pwmsr_pkg::cmd_t                cmd_o
);
  import pwmsr_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  logic [2:0] state_q, state_d;
  logic       needs_out;
  logic       in_fire;

  // reads and ticks wait for the output register to empty
  assign needs_out  = (action_i == ACT_READ) || (action_i == ACT_TICK);
  assign in_stall_o = (state_q != S_IDLE) || (st_i.out_valid && needs_out);
  assign in_fire    = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          unique case (action_i)
            ACT_SET_BRIGHT: cmd_o.wr_bright = 1'b1;
            ACT_SET_POS:    cmd_o.wr_pos    = 1'b1;
            ACT_ALL_ZERO:   cmd_o.fill_zero = 1'b1;
            ACT_ALL_MAX:    cmd_o.fill_max  = 1'b1;
            ACT_READ: begin
              cmd_o.rd_issue = 1'b1;
              state_d        = S_READ;
            end
            ACT_TICK: begin
              cmd_o.scan_start = 1'b1;
              state_d          = S_SCAN;
            end
            default: ;
          endcase
        end
      end
      S_READ: begin
        cmd_o.rd_load = 1'b1;
        state_d       = S_IDLE;
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (st_i.scan_last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (st_i.out_free) begin
          cmd_o.emit_load = 1'b1;
          if (st_i.emit_last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_emit_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.emit_load && st_i.emit_last) |=> (state_q == S_IDLE))
    else $error("sequencer did not return to idle after last bit");

  a_drain_after_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DRAIN) |-> ($past(state_q) == S_SCAN && $past(st_i.scan_last)))
    else $error("drain entered without finishing scan");

  a_read_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.rd_load |-> !st_i.out_valid)
    else $error("read result loaded over a pending item");

endmodule

>>> hw/rtl/pwm_shift_register_tube_driver.sv
// pwm_shift_register_tube_driver: top level of the PWM tube driver.
// Uses pwmsr_pkg, pwmsr_ctrl and pwmsr_datapath.
//
// Keeps one brightness byte per element (60 digit elements, tube-major,
// then 4 colon dots) and one shift position per digit element. Set actions
// (brightness, position, all zero, all max) give no item. A read returns one
// item via the memory read register and the output register. A refresh tick
// computes phase = time_ms mod 64 and scans all 64 elements, one per cycle,
// through the brightness and position memories, then shifts out 60 active-low
// bits from position 59 down to 0, one per cycle while the sink does not
// stall; the last bit carries the lit dots. A tick runs a start step, the
// scan (paced by the single memory read port), a drain step and the output
// steps. Set actions are taken while a result still waits in the output
// register; reads and ticks wait until it is taken. The brightness table
// resets to zero at once (per-entry valid bits); positions are undefined
// until written.
module pwm_shift_register_tube_driver (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // input channel
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [pwmsr_pkg::ACTION_W-1:0] action_i,
  input  logic [pwmsr_pkg::ELEM_W-1:0]   elem_sel_i,
  input  logic [pwmsr_pkg::BRIGHT_W-1:0] value_i,
  input  logic [pwmsr_pkg::TIME_W-1:0]   time_ms_i,
  // output channel
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           serial_bit_o,
  output logic [pwmsr_pkg::BITPOS_W-1:0] bit_position_o,
  output logic [pwmsr_pkg::DOTS_W-1:0]   colon_dots_o,
  output logic [pwmsr_pkg::BRIGHT_W-1:0] read_value_o,
  output logic                           last_o
);
  import pwmsr_pkg::*;

  cmd_t cmd;  // sequencer commands
  st_t  st;   // datapath status

  // Sequencer: decodes the accepted item and steps scan / emit
  pwmsr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .action_i   (action_i),
    .in_stall_o (in_stall_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  // Datapath: tables, scan pipeline, output register
  pwmsr_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .st_o           (st),
    .elem_sel_i     (elem_sel_i),
    .value_i        (value_i),
    .time_ms_i      (time_ms_i),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .serial_bit_o   (serial_bit_o),
    .bit_position_o (bit_position_o),
    .colon_dots_o   (colon_dots_o),
    .read_value_o   (read_value_o),
    .last_o         (last_o)
  );

endmodule

>>> verif/tb_pwm_shift_register_tube_driver.sv
// Testbench for the PWM shift register tube driver: directed and random actions with
// an in-bench display model that predicts every shifted bit and every read-back.
// Depends on pwmsr_pkg and pwm_shift_register_tube_driver.
module tb_pwm_shift_register_tube_driver;
  timeunit 1ns;
  timeprecision 1ps;

  import pwmsr_pkg::*;

  // Codes 6 and 7 have no action behind them
  localparam logic [ACTION_W-1:0] ACT_SPARE_6 = 3'd6;
  localparam logic [ACTION_W-1:0] ACT_SPARE_7 = 3'd7;

  localparam int RESET_CYCLES = 9;
  localparam int HOLD_CYCLES  = 400;   // long receiver hold-off
  localparam int DRAIN_CYCLES = 150;   // a bit more than one full tick
  localparam int RANDOM_ITEMS = 110;
  localparam int LIMIT_NS     = 4_000_000;

  // One shifted bit or one read-back, as seen on the output port
  typedef struct packed {
    logic                serial_bit;
    logic [BITPOS_W-1:0] bit_position;
    logic [DOTS_W-1:0]   colon_dots;
    logic [BRIGHT_W-1:0] read_value;
    logic                last;
  } shift_item_t;

  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                in_valid_i     = 1'b0;
  logic                in_stall_o;
  logic [ACTION_W-1:0] action_i       = ACT_SET_BRIGHT;
  logic [ELEM_W-1:0]   elem_sel_i     = '0;
  logic [BRIGHT_W-1:0] value_i        = '0;
  logic [TIME_W-1:0]   time_ms_i      = '0;
  logic                out_valid_o;
  logic                out_stall_i    = 1'b0;
  logic                serial_bit_o;
  logic [BITPOS_W-1:0] bit_position_o;
  logic [DOTS_W-1:0]   colon_dots_o;
  logic [BRIGHT_W-1:0] read_value_o;
  logic                last_o;

  // Display model state: brightness per element, shift position per digit
  logic [BRIGHT_W-1:0] bright_mdl [NUM_ELEMS];
  logic [BITPOS_W-1:0] pos_mdl    [NUM_DIGITS];

  shift_item_t pending_shift_q [$];   // bits and read-backs still to come out

  int mismatch_count = 0;
  int send_idle_pct  = 0;
  int recv_idle_pct  = 0;
  int hold_left      = 0;             // receiver hold-off, counted down below

  always #5 clk_i = ~clk_i;

  pwm_shift_register_tube_driver u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .action_i       (action_i),
    .elem_sel_i     (elem_sel_i),
    .value_i        (value_i),
    .time_ms_i      (time_ms_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .serial_bit_o   (serial_bit_o),
    .bit_position_o (bit_position_o),
    .colon_dots_o   (colon_dots_o),
    .read_value_o   (read_value_o),
    .last_o         (last_o)
  );

  // ---------------------------------------------------------------------------
  // Display model: applies one accepted action, queues the items it causes.
  // ---------------------------------------------------------------------------
  task automatic model_display_action(input logic [ACTION_W-1:0] act,
                                      input logic [ELEM_W-1:0] elem,
                                      input logic [BRIGHT_W-1:0] val,
                                      input logic [TIME_W-1:0] ms);
    int unsigned             phase;
    logic [NUM_DIGITS-1:0]   driven;
    logic [DOTS_W-1:0]       dots;
    shift_item_t             item;
    case (act)
      ACT_SET_BRIGHT: begin
        if (elem < NUM_ELEMS) bright_mdl[elem] = val;
      end
      ACT_SET_POS: begin
        // dots have no position; out-of-range positions leave the map alone
        if (elem < NUM_DIGITS && val < NUM_DIGITS) pos_mdl[elem] = val[BITPOS_W-1:0];
      end
      ACT_ALL_ZERO: begin
        foreach (bright_mdl[i]) bright_mdl[i] = '0;
      end
      ACT_ALL_MAX: begin
        foreach (bright_mdl[i]) bright_mdl[i] = BRIGHT_W'(BRIGHT_STEPS);
      end
      ACT_READ: begin
        item            = '0;
        item.serial_bit = 1'b1;
        item.read_value = (elem < NUM_ELEMS) ? bright_mdl[elem] : '0;
        pending_shift_q.push_back(item);
      end
      ACT_TICK: begin
        phase  = ms % BRIGHT_STEPS;
        driven = '0;
        dots   = '0;
        for (int i = 0; i < NUM_DIGITS; i++) begin
          if (bright_mdl[i] > phase && pos_mdl[i] < NUM_DIGITS) driven[pos_mdl[i]] = 1'b1;
        end
        for (int i = 0; i < NUM_DOTS; i++) begin
          if (bright_mdl[NUM_DIGITS + i] > phase) dots[i] = 1'b1;
        end
        // active low, top position first; the final bit carries the dots
        for (int p = NUM_DIGITS - 1; p >= 0; p--) begin
          item              = '0;
          item.serial_bit   = ~driven[p];
          item.bit_position = BITPOS_W'(p);
          item.colon_dots   = (p == 0) ? dots : '0;
          item.last         = (p == 0);
          pending_shift_q.push_back(item);
        end
      end
      default: ;  // spare codes: nothing happens
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Sender: optional idle cycles, then offer the item until it is taken.
  // Valid is left high on return; an idle cycle in the next call, or the wrap-up, lowers it.
  // ---------------------------------------------------------------------------
  task automatic send_action(input logic [ACTION_W-1:0] act,
                             input logic [ELEM_W-1:0] elem,
                             input logic [BRIGHT_W-1:0] val,
                             input logic [TIME_W-1:0] ms);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i   <= act;
    elem_sel_i <= elem;
    value_i    <= val;
    time_ms_i  <= ms;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    model_display_action(act, elem, val, ms);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver stall: random, or held high while a hold-off is running
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      mismatch_count++;
    end
  endtask

  // Every taken output item is matched against the oldest prediction
  always @(posedge clk_i) begin
    shift_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_shift_q.size() == 0) begin
        $display("%0t ns: unexpected item, expected none, actual bit %0h pos %0d",
                 $time, serial_bit_o, bit_position_o);
        mismatch_count++;
      end else begin
        want = pending_shift_q.pop_front();
        check_field("serial_bit",   32'(want.serial_bit),   32'(serial_bit_o));
        check_field("bit_position", 32'(want.bit_position), 32'(bit_position_o));
        check_field("colon_dots",   32'(want.colon_dots),   32'(colon_dots_o));
        check_field("read_value",   32'(want.read_value),   32'(read_value_o));
        check_field("last",         32'(want.last),         32'(last_o));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Brightness table comes out of reset at zero, dots included
  task automatic test_reset_readback();
    send_action(ACT_READ, '0, BRIGHT_W'($urandom), $urandom);
    send_action(ACT_READ, ELEM_W'(NUM_DIGITS - 1), BRIGHT_W'($urandom), $urandom);
    send_action(ACT_READ, ELEM_W'(NUM_DIGITS), BRIGHT_W'($urandom), $urandom);
    send_action(ACT_READ, ELEM_W'(NUM_ELEMS - 1), BRIGHT_W'($urandom), $urandom);
  endtask

  // Every digit gets a position before any tick; then the ignored cases:
  // a position on a dot and positions past the last one
  task automatic test_position_map();
    for (int i = 0; i < NUM_DIGITS; i++)
      send_action(ACT_SET_POS, ELEM_W'(i), BRIGHT_W'($urandom_range(NUM_DIGITS - 1)),
                  $urandom);
    send_action(ACT_SET_POS, ELEM_W'(NUM_ELEMS - 2), 8'd5, $urandom);
    send_action(ACT_SET_POS, 6'd3, BRIGHT_W'(NUM_DIGITS), $urandom);
    send_action(ACT_SET_POS, 6'd4, 8'hFF, $urandom);
  endtask

  // Brightness extremes against phase 0 and phase 63
  task automatic test_brightness_edges();
    send_action(ACT_SET_BRIGHT, '0, 8'hFF, $urandom);
    send_action(ACT_SET_BRIGHT, 6'd1, 8'h00, $urandom);
    send_action(ACT_SET_BRIGHT, 6'd2, 8'd1, $urandom);
    send_action(ACT_SET_BRIGHT, ELEM_W'(NUM_DIGITS), 8'd1, $urandom);
    send_action(ACT_SET_BRIGHT, ELEM_W'(NUM_ELEMS - 1), 8'h80, $urandom);
    send_action(ACT_READ, '0, BRIGHT_W'($urandom), $urandom);
    send_action(ACT_READ, ELEM_W'(NUM_ELEMS - 1), BRIGHT_W'($urandom), $urandom);
    send_action(ACT_TICK, ELEM_W'($urandom), BRIGHT_W'($urandom), 32'h0000_0000);
    send_action(ACT_TICK, ELEM_W'($urandom), BRIGHT_W'($urandom), 32'hFFFF_FFFF);
  endtask

  // All max lights everything even at the top phase; all zero lights nothing
  task automatic test_fill_actions();
    send_action(ACT_ALL_MAX, ELEM_W'($urandom), BRIGHT_W'($urandom), $urandom);
    send_action(ACT_READ, 6'd5, BRIGHT_W'($urandom), $urandom);
    send_action(ACT_TICK, ELEM_W'($urandom), BRIGHT_W'($urandom), 32'd63);
    send_action(ACT_ALL_ZERO, ELEM_W'($urandom), BRIGHT_W'($urandom), $urandom);
    send_action(ACT_TICK, ELEM_W'($urandom), BRIGHT_W'($urandom), 32'hFFFF_FFC0);
    send_action(ACT_READ, ELEM_W'(NUM_DIGITS), BRIGHT_W'($urandom), $urandom);
  endtask

  task automatic test_spare_actions();
    send_action(ACT_SPARE_6, ELEM_W'($urandom), BRIGHT_W'($urandom), $urandom);
    send_action(ACT_SPARE_7, ELEM_W'($urandom), BRIGHT_W'($urandom), $urandom);
  endtask

  // Receiver holds off while ticks and reads keep coming: the output
  // register fills and the input must stall
  task automatic test_output_hold();
    hold_left = HOLD_CYCLES;
    send_action(ACT_SET_BRIGHT, 6'd7, 8'd40, $urandom);
    send_action(ACT_TICK, ELEM_W'($urandom), BRIGHT_W'($urandom), $urandom);
    send_action(ACT_READ, 6'd7, BRIGHT_W'($urandom), $urandom);
    send_action(ACT_TICK, ELEM_W'($urandom), BRIGHT_W'($urandom), $urandom);
    send_action(ACT_READ, 6'd0, BRIGHT_W'($urandom), $urandom);
  endtask

  // Random mix; ignored items do not count toward n_items
  task automatic test_random_actions(input int n_items);
    int                  taken;
    int                  pick;
    logic [ELEM_W-1:0]   elem;
    logic [BRIGHT_W-1:0] val;
    taken = 0;
    while (taken < n_items) begin
      pick = int'($urandom_range(99));
      elem = ELEM_W'($urandom);
      if (pick < 30) begin
        send_action(ACT_TICK, elem, BRIGHT_W'($urandom), $urandom);
        taken++;
      end else if (pick < 55) begin
        // mostly near the phase range, sometimes anywhere
        val = ($urandom_range(1) == 0) ? BRIGHT_W'($urandom_range(BRIGHT_STEPS + 8))
                                       : BRIGHT_W'($urandom);
        send_action(ACT_SET_BRIGHT, elem, val, $urandom);
        taken++;
      end else if (pick < 70) begin
        val = ($urandom_range(4) != 0) ? BRIGHT_W'($urandom_range(NUM_DIGITS - 1))
                                       : BRIGHT_W'($urandom);
        send_action(ACT_SET_POS, elem, val, $urandom);
        if (elem < NUM_DIGITS && val < NUM_DIGITS) taken++;
      end else if (pick < 84) begin
        send_action(ACT_READ, elem, BRIGHT_W'($urandom), $urandom);
        taken++;
      end else if (pick < 88) begin
        send_action(ACT_ALL_ZERO, elem, BRIGHT_W'($urandom), $urandom);
        taken++;
      end else if (pick < 93) begin
        send_action(ACT_ALL_MAX, elem, BRIGHT_W'($urandom), $urandom);
        taken++;
      end else begin
        send_action(($urandom_range(1) == 0) ? ACT_SPARE_6 : ACT_SPARE_7,
                    elem, BRIGHT_W'($urandom), $urandom);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    foreach (bright_mdl[i]) bright_mdl[i] = '0;
    foreach (pos_mdl[i]) pos_mdl[i] = '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 17;
    recv_idle_pct = 54;
    test_reset_readback();
    test_position_map();   // must precede the first tick
    test_brightness_edges();
    test_fill_actions();
    test_spare_actions();
    test_output_hold();
    test_random_actions(RANDOM_ITEMS / 3);

    send_idle_pct = 54;
    recv_idle_pct = 17;
    test_random_actions(RANDOM_ITEMS / 3);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_actions(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));
    in_valid_i <= 1'b0;

    while (pending_shift_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #(LIMIT_NS);
    $display("Verification failed");
    $finish;
  end

endmodule
